// ===== hw/rtl/eigenvector_from_cofactors_defines.svh =====
// Assertion helpers for the top-level RTL; they expect clk and rst_n in scope.
`ifndef EIGENVECTOR_FROM_COFACTORS_DEFINES_SVH
`define EIGENVECTOR_FROM_COFACTORS_DEFINES_SVH

`define EVC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define EVC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/evc_pkg.sv =====
package evc_pkg;

  localparam int M_W      = 31;  // normalized magnitude width
  localparam int SUM_W    = 64;  // sum of squares width
  localparam int SQ_W     = 32;  // integer square root width
  localparam int SQ_STEPS = 32;  // one root bit per stage
  localparam int OUT_W    = 32;
  localparam int GRP_W    = 8;   // leading-one search group width

  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  typedef struct packed {
    logic       degenerate;
    axis_t      pivot;
    logic [2:0] neg;
  } meta_t;

  function automatic logic [3:0] bitlen8(input logic [GRP_W-1:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < GRP_W; i++) begin
      if (v[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

// ===== hw/rtl/evc_cofactor.sv =====
module evc_cofactor #(
  parameter int IN_WIDTH = 32,
  parameter int CW       = 2 * (IN_WIDTH + 1) + 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic signed [IN_WIDTH-1:0] m_xx,
  input  logic signed [IN_WIDTH-1:0] m_xy,
  input  logic signed [IN_WIDTH-1:0] m_xz,
  input  logic signed [IN_WIDTH-1:0] m_yy,
  input  logic signed [IN_WIDTH-1:0] m_yz,
  input  logic signed [IN_WIDTH-1:0] m_zz,
  input  logic signed [IN_WIDTH-1:0] lam,
  output logic                       out_valid,
  output logic signed [CW-1:0]       cof [6]
);

  localparam int BW = IN_WIDTH + 1;
  localparam int PW = 2 * BW;

  logic              v1_r, v2_r, v3_r;
  logic signed [BW-1:0] b0_r, b1_r, b2_r, b4_r, b5_r, b8_r;
  logic signed [PW-1:0] pr_r  [12];
  logic signed [PW-1:0] pr_nxt[12];
  logic signed [CW-1:0] cof_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // B = A - lambda*I, one bit wider so the difference is exact.
  always_ff @(posedge clk) begin
    b0_r <= BW'(m_xx) - BW'(lam);
    b1_r <= BW'(m_xy);
    b2_r <= BW'(m_xz);
    b4_r <= BW'(m_yy) - BW'(lam);
    b5_r <= BW'(m_yz);
    b8_r <= BW'(m_zz) - BW'(lam);
  end

  always_comb begin
    pr_nxt[0]  = b4_r * b8_r;
    pr_nxt[1]  = b5_r * b5_r;
    pr_nxt[2]  = b0_r * b8_r;
    pr_nxt[3]  = b2_r * b2_r;
    pr_nxt[4]  = b0_r * b4_r;
    pr_nxt[5]  = b1_r * b1_r;
    pr_nxt[6]  = b2_r * b5_r;
    pr_nxt[7]  = b1_r * b8_r;
    pr_nxt[8]  = b1_r * b5_r;
    pr_nxt[9]  = b2_r * b4_r;
    pr_nxt[10] = b1_r * b2_r;
    pr_nxt[11] = b0_r * b5_r;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 12; i++) begin
      pr_r[i] <= pr_nxt[i];
    end
    // Diagonal cofactors first, then the off-diagonal ones p, q, r.
    for (int i = 0; i < 6; i++) begin
      cof_r[i] <= CW'(pr_r[2*i]) - CW'(pr_r[2*i+1]);
    end
  end

  assign out_valid = v3_r;
  assign cof       = cof_r;

endmodule

// ===== hw/rtl/evc_norm.sv =====
module evc_norm #(
  parameter int CW = 67
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic signed [CW-1:0]              cof [6],
  output logic                              out_valid,
  output evc_pkg::meta_t                    out_meta,
  output logic [2:0][evc_pkg::M_W-1:0]      out_m,
  output logic [evc_pkg::SUM_W-1:0]         out_sum
);

  localparam int M_W = evc_pkg::M_W;
  localparam int NG  = (CW + evc_pkg::GRP_W - 1) / evc_pkg::GRP_W;
  localparam int OW  = NG * evc_pkg::GRP_W;
  localparam int LW  = $clog2(CW + 1);

  logic [6:0] vld_r;

  logic [CW-1:0]      mag_r [6];
  logic [5:0]         sgn_r;
  logic               c01_r, c02_r, c12_r, zero_r;

  logic [2:0][CW-1:0] mg2_r, mg3_r, mg4_r;
  logic [2:0][CW-1:0] mg_nxt;
  evc_pkg::meta_t     meta2_r, meta3_r, meta4_r, meta5_r, meta6_r, meta7_r;
  evc_pkg::meta_t     meta_nxt;

  logic [3:0]         glen_r [NG];
  logic [NG-1:0]      gnz_r;
  logic [OW-1:0]      orv;
  logic [LW-1:0]      lmax_r, lmax_nxt;

  logic [2:0][M_W-1:0]   m_r, m_nxt;
  logic [2*M_W-1:0]      sq_r [3];
  logic [evc_pkg::SUM_W-1:0] sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  // Stage 1: magnitudes and the pairwise compares of the diagonal ones.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++) begin
      sgn_r[i] <= cof[i][CW-1];
      mag_r[i] <= cof[i][CW-1] ? $unsigned(-cof[i]) : $unsigned(cof[i]);
    end
  end

  always_ff @(posedge clk) begin
    c01_r  <= (cof[1][CW-1] ? $unsigned(-cof[1]) : $unsigned(cof[1])) >
              (cof[0][CW-1] ? $unsigned(-cof[0]) : $unsigned(cof[0]));
    c02_r  <= (cof[2][CW-1] ? $unsigned(-cof[2]) : $unsigned(cof[2])) >
              (cof[0][CW-1] ? $unsigned(-cof[0]) : $unsigned(cof[0]));
    c12_r  <= (cof[2][CW-1] ? $unsigned(-cof[2]) : $unsigned(cof[2])) >
              (cof[1][CW-1] ? $unsigned(-cof[1]) : $unsigned(cof[1]));
    zero_r <= (cof[0] == '0) && (cof[1] == '0) && (cof[2] == '0);
  end

  // Stage 2: pivot choice; the first of equal magnitudes wins.
  always_comb begin
    meta_nxt.degenerate = zero_r;
    if (c01_r ? c12_r : c02_r) begin
      meta_nxt.pivot = evc_pkg::AXIS_Z;
    end else if (c01_r) begin
      meta_nxt.pivot = evc_pkg::AXIS_Y;
    end else begin
      meta_nxt.pivot = evc_pkg::AXIS_X;
    end
    unique case (meta_nxt.pivot)
      evc_pkg::AXIS_Y: begin
        mg_nxt       = {mag_r[5], mag_r[1], mag_r[3]};
        meta_nxt.neg = {sgn_r[5], sgn_r[1], sgn_r[3]} ^ {3{sgn_r[1]}};
      end
      evc_pkg::AXIS_Z: begin
        mg_nxt       = {mag_r[2], mag_r[5], mag_r[4]};
        meta_nxt.neg = {sgn_r[2], sgn_r[5], sgn_r[4]} ^ {3{sgn_r[2]}};
      end
      default: begin
        mg_nxt       = {mag_r[4], mag_r[3], mag_r[0]};
        meta_nxt.neg = {sgn_r[4], sgn_r[3], sgn_r[0]} ^ {3{sgn_r[0]}};
      end
    endcase
  end

  // Stage 3: bit length of each byte of the combined magnitude.
  assign orv = OW'(mg2_r[0] | mg2_r[1] | mg2_r[2]);

  // Stage 4: the highest nonzero byte gives the bit length of the largest value.
  always_comb begin
    lmax_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      if (gnz_r[g]) lmax_nxt = LW'(g * evc_pkg::GRP_W + int'(glen_r[g]));
    end
  end

  // Stage 5: bring the largest magnitude into [2^30, 2^31).
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (lmax_r > LW'(M_W)) begin
        m_nxt[k] = M_W'(mg4_r[k] >> (lmax_r - LW'(M_W)));
      end else begin
        m_nxt[k] = M_W'(mg4_r[k] << (LW'(M_W) - lmax_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    mg2_r   <= mg_nxt;
    meta2_r <= meta_nxt;
    for (int g = 0; g < NG; g++) begin
      glen_r[g] <= evc_pkg::bitlen8(orv[g*evc_pkg::GRP_W +: evc_pkg::GRP_W]);
      gnz_r[g]  <= |orv[g*evc_pkg::GRP_W +: evc_pkg::GRP_W];
    end
    mg3_r   <= mg2_r;
    meta3_r <= meta2_r;
    lmax_r  <= lmax_nxt;
    mg4_r   <= mg3_r;
    meta4_r <= meta3_r;
    m_r     <= m_nxt;
    meta5_r <= meta4_r;
    for (int k = 0; k < 3; k++) begin
      sq_r[k] <= m_r[k] * m_r[k];
    end
    meta6_r <= meta5_r;
    sum_r   <= evc_pkg::SUM_W'(sq_r[0]) + evc_pkg::SUM_W'(sq_r[1]) +
               evc_pkg::SUM_W'(sq_r[2]);
    meta7_r <= meta6_r;
  end

  // The shifted magnitudes wait two stages beside the squares and the sum.
  logic [2:0][M_W-1:0] m6_r, m7_r;
  always_ff @(posedge clk) begin
    m6_r <= m_r;
    m7_r <= m6_r;
  end

  assign out_valid = vld_r[6];
  assign out_meta  = meta7_r;
  assign out_m     = m7_r;
  assign out_sum   = sum_r;

endmodule

// ===== hw/rtl/evc_isqrt.sv =====
module evc_isqrt #(
  parameter int PAY_W = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [evc_pkg::SUM_W-1:0]     in_x,
  input  logic [PAY_W-1:0]              in_pay,
  output logic                          out_valid,
  output logic [evc_pkg::SQ_W-1:0]      out_root,
  output logic [PAY_W-1:0]              out_pay
);

  localparam int N  = evc_pkg::SQ_STEPS;
  localparam int XW = evc_pkg::SUM_W;

  logic [N:0]    vld;
  logic [XW-1:0] x   [N+1];
  logic [XW-1:0] res [N+1];
  logic [PAY_W-1:0] pay [N+1];

  assign vld[0] = in_valid;
  assign x[0]   = in_x;
  assign res[0] = '0;
  assign pay[0] = in_pay;

  // One root bit per stage, from the top pair of bits down.
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [XW-1:0] BIT = XW'(1) << (2 * (N - 1 - k));
    logic          vld_r;
    logic [XW-1:0] x_r, res_r, x_nxt, res_nxt;
    logic [PAY_W-1:0] pay_r;

    always_comb begin
      if (x[k] >= res[k] + BIT) begin
        x_nxt   = x[k] - (res[k] + BIT);
        res_nxt = (res[k] >> 1) + BIT;
      end else begin
        x_nxt   = x[k];
        res_nxt = res[k] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      x_r   <= x_nxt;
      res_r <= res_nxt;
      pay_r <= pay[k];
    end

    assign vld[k+1] = vld_r;
    assign x[k+1]   = x_r;
    assign res[k+1] = res_r;
    assign pay[k+1] = pay_r;
  end

  assign out_valid = vld[N];
  assign out_root  = evc_pkg::SQ_W'(res[N]);
  assign out_pay   = pay[N];

endmodule

// ===== hw/rtl/evc_div.sv =====
module evc_div #(
  parameter int OUT_FRAC_BITS = 30,
  parameter int QB            = OUT_FRAC_BITS + 2
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [evc_pkg::SQ_W-1:0]         in_root,
  input  logic [2:0][evc_pkg::M_W-1:0]     in_m,
  input  evc_pkg::meta_t                   in_meta,
  output logic                             out_valid,
  output logic [2:0][QB-1:0]               out_q,
  output evc_pkg::meta_t                   out_meta
);

  localparam int SW = evc_pkg::SQ_W;
  localparam int NW = evc_pkg::M_W + OUT_FRAC_BITS + 1;

  logic [QB:0]        vld;
  logic [SW-1:0]      dv  [QB+1];
  logic [2:0][SW-1:0] rem [QB+1];
  logic [2:0][QB-1:0] ql  [QB+1];
  evc_pkg::meta_t     mt  [QB+1];

  // Numerator with half the divisor added for rounding; its upper part is
  // already below the divisor, so only QB quotient bits remain to find.
  for (genvar k = 0; k < 3; k++) begin : g_num
    assign rem[0][k] = SW'((((NW'(in_m[k]) << OUT_FRAC_BITS) + NW'(in_root >> 1))) >> QB);
    assign ql[0][k]  = QB'(((NW'(in_m[k]) << OUT_FRAC_BITS) + NW'(in_root >> 1)));
  end

  assign vld[0] = in_valid;
  assign dv[0]  = in_root;
  assign mt[0]  = in_meta;

  // The quotient bits shift in as the numerator bits shift out.
  for (genvar j = 0; j < QB; j++) begin : g_step
    logic               vld_r;
    logic [SW-1:0]      dv_r;
    logic [2:0][SW-1:0] rem_r, rem_nxt;
    logic [2:0][QB-1:0] ql_r, ql_nxt;
    evc_pkg::meta_t     mt_r;
    logic [SW:0]        t [3];

    always_comb begin
      for (int k = 0; k < 3; k++) begin
        t[k] = {rem[j][k], ql[j][k][QB-1]};
        if (t[k] >= {1'b0, dv[j]}) begin
          rem_nxt[k] = SW'(t[k] - {1'b0, dv[j]});
          ql_nxt[k]  = {ql[j][k][QB-2:0], 1'b1};
        end else begin
          rem_nxt[k] = SW'(t[k]);
          ql_nxt[k]  = {ql[j][k][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r <= 1'b0;
      end else begin
        vld_r <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      dv_r  <= dv[j];
      rem_r <= rem_nxt;
      ql_r  <= ql_nxt;
      mt_r  <= mt[j];
    end

    assign vld[j+1] = vld_r;
    assign dv[j+1]  = dv_r;
    assign rem[j+1] = rem_r;
    assign ql[j+1]  = ql_r;
    assign mt[j+1]  = mt_r;
  end

  assign out_valid = vld[QB];
  assign out_q     = ql[QB];
  assign out_meta  = mt[QB];

endmodule

// ===== hw/rtl/eigenvector_from_cofactors.sv =====
// Channel   Ports                                  Handshake
// input     in_m_xx .. in_m_zz, in_eigen_value     start high, busy low
// result    out_vec_x/y/z, out_pivot_axis,         out_valid, one cycle
//           out_degenerate
//
// A new transaction is taken every cycle; busy is always low.
// Pipeline order: cofactors, pivot choice and normalization, square root (one
// bit per stage), the three dividers and the output register.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall, so the pipeline never stops.
`include "eigenvector_from_cofactors_defines.svh"

module eigenvector_from_cofactors #(
  parameter int IN_FRAC_BITS  = 16,
  parameter int OUT_FRAC_BITS = 30,
  parameter int IN_WIDTH      = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [IN_WIDTH-1:0]        in_m_xx,
  input  logic signed [IN_WIDTH-1:0]        in_m_xy,
  input  logic signed [IN_WIDTH-1:0]        in_m_xz,
  input  logic signed [IN_WIDTH-1:0]        in_m_yy,
  input  logic signed [IN_WIDTH-1:0]        in_m_yz,
  input  logic signed [IN_WIDTH-1:0]        in_m_zz,
  input  logic signed [IN_WIDTH-1:0]        in_eigen_value,
  output logic                              out_valid,
  output logic signed [evc_pkg::OUT_W-1:0]  out_vec_x,
  output logic signed [evc_pkg::OUT_W-1:0]  out_vec_y,
  output logic signed [evc_pkg::OUT_W-1:0]  out_vec_z,
  output logic [1:0]                        out_pivot_axis,
  output logic                              out_degenerate
);

  // The input scale cancels in the normalization; the fraction width only
  // documents the format.
  localparam int FRAC_IN = IN_FRAC_BITS;
  localparam int CW      = 2 * (IN_WIDTH + 1) + 1;
  localparam int QB      = OUT_FRAC_BITS + 2;
  localparam int PAY_W   = $bits(evc_pkg::meta_t) + 3 * evc_pkg::M_W;
  localparam int LAT     = OUT_FRAC_BITS + 45 + FRAC_IN * 0;
  localparam int OW      = evc_pkg::OUT_W;

  logic                       acc;
  logic                       cof_vld;
  logic signed [CW-1:0]       cof [6];
  logic                       nrm_vld;
  evc_pkg::meta_t             nrm_meta;
  logic [2:0][evc_pkg::M_W-1:0] nrm_m;
  logic [evc_pkg::SUM_W-1:0]  nrm_sum;
  logic                       sq_vld;
  logic [evc_pkg::SQ_W-1:0]   sq_root;
  logic [PAY_W-1:0]           sq_pay;
  evc_pkg::meta_t             sq_meta;
  logic [2:0][evc_pkg::M_W-1:0] sq_m;
  logic                       dv_vld;
  logic [2:0][QB-1:0]         dv_q;
  evc_pkg::meta_t             dv_meta;

  logic                       valid_r;
  logic [2:0][OW-1:0]         vec_r, vec_nxt;
  logic [1:0]                 axis_r;
  logic                       degen_r;
  logic [QB-1:0]              o;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  evc_cofactor #(.IN_WIDTH(IN_WIDTH), .CW(CW)) u_cof (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .m_xx      (in_m_xx),
    .m_xy      (in_m_xy),
    .m_xz      (in_m_xz),
    .m_yy      (in_m_yy),
    .m_yz      (in_m_yz),
    .m_zz      (in_m_zz),
    .lam       (in_eigen_value),
    .out_valid (cof_vld),
    .cof       (cof)
  );

  evc_norm #(.CW(CW)) u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cof_vld),
    .cof       (cof),
    .out_valid (nrm_vld),
    .out_meta  (nrm_meta),
    .out_m     (nrm_m),
    .out_sum   (nrm_sum)
  );

  evc_isqrt #(.PAY_W(PAY_W)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (nrm_vld),
    .in_x      (nrm_sum),
    .in_pay    ({nrm_meta, nrm_m}),
    .out_valid (sq_vld),
    .out_root  (sq_root),
    .out_pay   (sq_pay)
  );

  assign {sq_meta, sq_m} = sq_pay;

  evc_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .QB(QB)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_vld),
    .in_root   (sq_root),
    .in_m      (sq_m),
    .in_meta   (sq_meta),
    .out_valid (dv_vld),
    .out_q     (dv_q),
    .out_meta  (dv_meta)
  );

  // Saturate to one, then apply the sign relative to the pivot component; a degenerate result gives zero.
  always_comb begin
    o = '0;
    for (int k = 0; k < 3; k++) begin
      o = (dv_q[k] > (QB'(1) << OUT_FRAC_BITS)) ? (QB'(1) << OUT_FRAC_BITS) : dv_q[k];
      if (dv_meta.degenerate) begin
        vec_nxt[k] = '0;
      end else if (dv_meta.neg[k]) begin
        vec_nxt[k] = OW'(-OW'(o));
      end else begin
        vec_nxt[k] = OW'(o);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    vec_r   <= vec_nxt;
    axis_r  <= dv_meta.degenerate ? evc_pkg::AXIS_X : dv_meta.pivot;
    degen_r <= dv_meta.degenerate;
  end

  assign out_valid      = valid_r;
  assign out_vec_x      = vec_r[0];
  assign out_vec_y      = vec_r[1];
  assign out_vec_z      = vec_r[2];
  assign out_pivot_axis = axis_r;
  assign out_degenerate = degen_r;

  `EVC_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate,
    out_vec_x == '0 && out_vec_y == '0 && out_vec_z == '0 &&
    out_pivot_axis == evc_pkg::AXIS_X, "degenerate result is not a zero vector")
  `EVC_ASSERT_IMP(a_pivot_pos, out_valid && !out_degenerate,
    (out_pivot_axis == evc_pkg::AXIS_X && !out_vec_x[OW-1]) ||
    (out_pivot_axis == evc_pkg::AXIS_Y && !out_vec_y[OW-1]) ||
    (out_pivot_axis == evc_pkg::AXIS_Z && !out_vec_z[OW-1]),
    "pivot component is negative or pivot axis is invalid")
  `EVC_ASSERT_IMP(a_latency, out_valid, $past(acc, LAT),
    "result without a transaction accepted at the pipeline latency")

endmodule

// ===== verif/tb_eigenvector_from_cofactors.sv =====
module tb_eigenvector_from_cofactors;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFB = 30;
  localparam int LATENCY = OFB + 45;
  localparam int WATCHDOG_LIMIT = 4 * LATENCY + 200;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    evc_pkg::axis_t     axis;
    logic               degen;
  } evec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_m_xx = '0, in_m_xy = '0, in_m_xz = '0, in_m_yy = '0;
  logic signed [31:0] in_m_yz = '0, in_m_zz = '0, in_eigen_value = '0;
  logic out_valid;
  logic signed [31:0] out_vec_x, out_vec_y, out_vec_z;
  logic [1:0] out_pivot_axis;
  logic out_degenerate;

  evec_t expected_vecs[$];
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_degen = 0;
  int quiet_cycles = 0;
  bit idle_enable = 1'b1;

  eigenvector_from_cofactors i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [127:0] cofactor(logic signed [63:0] a, logic signed [63:0] b,
                                                    logic signed [63:0] c, logic signed [63:0] d);
    logic signed [127:0] pa, pb;
    pa = 128'(a) * 128'(b);
    pb = 128'(c) * 128'(d);
    return pa - pb;
  endfunction

  function automatic logic [127:0] mag(logic signed [127:0] v);
    return v[127] ? 128'(-v) : 128'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic evec_t predict_eigenvector(logic signed [31:0] axx, axy, axz, ayy, ayz,
                                                azz, lam);
    evec_t r;
    logic signed [63:0] b0, b1, b2, b4, b5, b8;
    logic signed [127:0] dc[3], v[3];
    logic signed [127:0] p, q, rr;
    logic [127:0] best, mm, mg[3];
    logic [63:0] m[3], s, sq, o;
    int piv, len, lmax;
    bit flip, negc;
    b0 = 64'(axx) - 64'(lam);
    b1 = 64'(axy);
    b2 = 64'(axz);
    b4 = 64'(ayy) - 64'(lam);
    b5 = 64'(ayz);
    b8 = 64'(azz) - 64'(lam);
    dc[0] = cofactor(b4, b8, b5, b5);
    dc[1] = cofactor(b0, b8, b2, b2);
    dc[2] = cofactor(b0, b4, b1, b1);
    p = cofactor(b2, b5, b1, b8);
    q = cofactor(b1, b5, b2, b4);
    rr = cofactor(b1, b2, b0, b5);
    best = 0;
    piv = -1;
    for (int i = 0; i < 3; i++) begin
      mm = mag(dc[i]);
      if (mm > best) begin
        best = mm;
        piv = i;
      end
    end
    r = '{0, 0, 0, evc_pkg::AXIS_X, 1'b0};
    if (piv < 0) begin
      r.degen = 1'b1;
      return r;
    end
    case (piv)
      0: begin v[0] = dc[0]; v[1] = p; v[2] = q; end
      1: begin v[0] = p; v[1] = dc[1]; v[2] = rr; end
      default: begin v[0] = q; v[1] = rr; v[2] = dc[2]; end
    endcase
    flip = v[piv][127];
    lmax = 0;
    for (int k = 0; k < 3; k++) begin
      mg[k] = mag(v[k]);
      len = 0;
      for (int j = 0; j < 128; j++) if (mg[k][j]) len = j + 1;
      if (len > lmax) lmax = len;
    end
    s = 0;
    for (int k = 0; k < 3; k++) begin
      if (lmax > 31) m[k] = 64'(mg[k] >> (lmax - 31));
      else m[k] = mg[k][63:0] << (31 - lmax);
      s += m[k] * m[k];
    end
    sq = int_sqrt(s);
    for (int k = 0; k < 3; k++) begin
      o = ((m[k] << OFB) + (sq >> 1)) / sq;
      if (o > (64'd1 << OFB)) o = 64'd1 << OFB;
      negc = v[k][127] != flip;
      o = negc ? -o : o;
      case (k)
        0: r.vx = o[31:0];
        1: r.vy = o[31:0];
        default: r.vz = o[31:0];
      endcase
    end
    r.axis = evc_pkg::axis_t'(piv);
    return r;
  endfunction

  // Result checker; the block cannot be stalled, so every strobe is one transaction.
  always @(posedge clk) begin
    evec_t e;
    if (rst_n && out_valid) begin
      if (expected_vecs.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d z=%0d", $time, out_vec_x, out_vec_y,
                 out_vec_z);
        n_errors++;
      end else begin
        e = expected_vecs.pop_front();
        n_checked++;
        if (out_vec_x !== e.vx) begin
          $display("%0t: vec_x expected %0d actual %0d", $time, e.vx, out_vec_x); n_errors++;
        end
        if (out_vec_y !== e.vy) begin
          $display("%0t: vec_y expected %0d actual %0d", $time, e.vy, out_vec_y); n_errors++;
        end
        if (out_vec_z !== e.vz) begin
          $display("%0t: vec_z expected %0d actual %0d", $time, e.vz, out_vec_z); n_errors++;
        end
        if (out_pivot_axis !== e.axis) begin
          $display("%0t: pivot_axis expected %0d actual %0d", $time, e.axis, out_pivot_axis);
          n_errors++;
        end
        if (out_degenerate !== e.degen) begin
          $display("%0t: degenerate expected %0d actual %0d", $time, e.degen, out_degenerate);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Sends one matrix. The caller must leave start high between back-to-back transactions.
  task automatic send_matrix(logic signed [31:0] axx, axy, axz, ayy, ayz, azz, lam);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_m_xx <= axx; in_m_xy <= axy; in_m_xz <= axz; in_m_yy <= ayy;
    in_m_yz <= ayz; in_m_zz <= azz; in_eigen_value <= lam;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_vecs.push_back(predict_eigenvector(axx, axy, axz, ayy, ayz, azz, lam));
    if (expected_vecs[$].degen) n_degen++;
    n_sent++;
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_vecs.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_elem(int range_kind);
    case (range_kind)
      0: return $urandom();
      1: return $signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4;
      default: return $signed($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  task automatic test_directed();
    logic signed [31:0] mx, mn, one;
    mx = 32'h7fffffff;
    mn = 32'h80000000;
    one = 32'sd65536;
    send_matrix(0, 0, 0, 0, 0, 0, 0);                 // all cofactors zero
    send_matrix(one, 0, 0, one, 0, 0, one);           // diag(1, 1, 0) minus lambda: degenerate
    send_matrix(one, 0, 0, 2 * one, 0, 0, 3 * one);   // pivot y
    send_matrix(3 * one, 0, 0, 2 * one, 0, 0, one);   // pivot y, tie between y and z: first wins
    send_matrix(one, 0, 0, 3 * one, 0, 0, 2 * one);   // pivot x, tie with y, negative cofactor
    send_matrix(one, 0, 0, one, 0, 0, 0);             // pivot z
    send_matrix(mx, mx, mx, mx, mx, mx, mx);
    send_matrix(mn, mn, mn, mn, mn, mn, mn);
    send_matrix(mx, mn, mx, mn, mx, mn, mn);
    send_matrix(mn, mx, mn, mx, mn, mx, mx);
    send_matrix(mx, 0, 0, mn, 0, 0, 0);
    send_matrix(-1, -1, -1, -1, -1, -1, 32'sd1);
    send_matrix(2 * one, one, one, 2 * one, one, 2 * one, one);  // rank-one B
    send_matrix(2 * one, one, 0, 2 * one, one, 2 * one, 0);
    send_matrix(1, 1, 1, 1, 1, 1, 0);
    send_matrix(0, mx, 0, 0, 0, 0, 0);
    send_matrix(0, 0, mn, 0, 0, 0, 0);
    send_matrix(0, 0, 0, 0, mx, 0, 0);
    wait_drained();
  endtask

  task automatic test_random(int count, bit allow_idle);
    logic signed [31:0] e[7];
    int kind;
    idle_enable = allow_idle;
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 2);
      foreach (e[i]) e[i] = rand_elem(kind);
      if ($urandom_range(0, 9) == 0) begin
        e[1] = 0; e[2] = 0; e[4] = 0;   // diagonal matrix, lambda always a true eigenvalue
        e[6] = e[$urandom_range(0, 2) == 0 ? 0 : 3];
      end
      send_matrix(e[0], e[1], e[2], e[3], e[4], e[5], e[6]);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(500, 1'b1);
    wait_drained();          // sender holds off until the pipeline is empty
    test_random(500, 1'b0);
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d matrices (%0d degenerate); %0d results checked.", n_sent, n_degen,
             n_checked);
    if (n_errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== eigenvector_from_cofactors.f =====
+incdir+hw/rtl
hw/rtl/evc_pkg.sv
hw/rtl/evc_cofactor.sv
hw/rtl/evc_norm.sv
hw/rtl/evc_isqrt.sv
hw/rtl/evc_div.sv
hw/rtl/eigenvector_from_cofactors.sv
verif/tb_eigenvector_from_cofactors.sv
